// ===== hw/rtl/lats_pkg.sv =====
`timescale 1ns / 1ps

package lats_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TIMEOUT_POLLS   = 3'd0,
		REG_POLL_MS         = 3'd1,
		REG_RESULT_HOLD_MS  = 3'd2,
		REG_SUMMARY_HOLD_MS = 3'd3,
		REG_CENTER_PULSE_MS = 3'd4,
		REG_SETTLE_MS       = 3'd5,
		REG_ABSENT_HOLD_MS  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  timeout_polls;
		logic [7:0]  poll_ms;
		logic [15:0] result_hold_ms;
		logic [15:0] summary_hold_ms;
		logic [15:0] center_pulse_ms;
		logic [15:0] settle_ms;
		logic [15:0] absent_hold_ms;
	} cfg_t;

	localparam logic [1:0] DRV_STOP = 2'd0;
	localparam logic [1:0] DRV_FWD  = 2'd1;
	localparam logic [1:0] DRV_REV  = 2'd2;

	localparam logic [3:0] MSG_LOCK_OK     = 4'd0;
	localparam logic [3:0] MSG_UNLOCK_OK   = 4'd2;
	localparam logic [3:0] MSG_SUMMARY     = 4'd4;
	localparam logic [3:0] MSG_NO_HELMET   = 4'd8;
	localparam logic [3:0] MSG_NONE        = 4'd0;

	localparam logic [1:0] OUT_LOCK_OK   = 2'b01;
	localparam logic [1:0] OUT_UNLOCK_OK = 2'b10;

endpackage

// ===== hw/rtl/lats_cfg.sv =====
`timescale 1ns / 1ps

module lats_cfg import lats_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_polls   <= 8'd200;
			cfg_q.poll_ms         <= 8'd5;
			cfg_q.result_hold_ms  <= 16'd3000;
			cfg_q.summary_hold_ms <= 16'd4000;
			cfg_q.center_pulse_ms <= 16'd50;
			cfg_q.settle_ms       <= 16'd1000;
			cfg_q.absent_hold_ms  <= 16'd3000;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TIMEOUT_POLLS:   cfg_q.timeout_polls   <= cfg_data[7:0];
				REG_POLL_MS:         cfg_q.poll_ms         <= cfg_data[7:0];
				REG_RESULT_HOLD_MS:  cfg_q.result_hold_ms  <= cfg_data;
				REG_SUMMARY_HOLD_MS: cfg_q.summary_hold_ms <= cfg_data;
				REG_CENTER_PULSE_MS: cfg_q.center_pulse_ms <= cfg_data;
				REG_SETTLE_MS:       cfg_q.settle_ms       <= cfg_data;
				REG_ABSENT_HOLD_MS:  cfg_q.absent_hold_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lock_actuator_test_sequencer.sv =====
`timescale 1ns / 1ps

// Helmet lock actuator test sequencer. Each request is one 1 ms tick carrying
// the active-low reed, lock-limit and unlock-limit switch levels; each request
// yields exactly one result (motor drive, optional voice message code). A
// request is taken every cycle unless a held result is stalled: state and the
// result register update in the same cycle, and the result register frees
// itself when downstream takes its content, so throughput is one tick per clock
// unless stalled. A result appears in the cycle after its request is taken.
// Config writes are always accepted and take effect at the register's next use.

module lock_actuator_test_sequencer import lats_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               reed_level,
	input  logic               lock_level,
	input  logic               unlock_level,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         motor_drive,
	output logic               message_valid,
	output logic [3:0]         message_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_LOCK_POLL    = 4'd1,
		PH_LOCK_FAIL    = 4'd2,
		PH_UNLOCK_START = 4'd3,
		PH_UNLOCK_POLL  = 4'd4,
		PH_UNLOCK_FAIL  = 4'd5,
		PH_SUMMARY      = 4'd6,
		PH_CENTER       = 4'd7,
		PH_SETTLE       = 4'd8
	} phase_t;

	cfg_t cfg;

	phase_t      phase_q, phase_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  poll_q, poll_d;
	logic [1:0]  outcome_q, outcome_d;
	logic [1:0]  drive_q, drive_d;
	logic        msg_v;
	logic [3:0]  msg_c;

	logic        out_valid_q;
	logic [1:0]  out_drive_q;
	logic        out_msg_v_q;
	logic [3:0]  out_msg_c_q;

	logic        accept;

	// shared poll step
	logic        poll_lock;
	logic        poll_level;
	logic [7:0]  poll_cur;
	logic [7:0]  poll_inc;
	logic [3:0]  ok_code;
	logic [1:0]  ok_bit;
	phase_t      poll_ph, fail_ph, next_ph;

	lats_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_stall = out_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	function automatic logic [15:0] wait_load(input logic [15:0] d);
		wait_load = (d == 16'd0) ? 16'd0 : d - 16'd1;
	endfunction

	always_comb begin
		poll_lock  = (phase_q == PH_IDLE) || (phase_q == PH_LOCK_POLL);
		poll_level = poll_lock ? lock_level : unlock_level;
		poll_cur   = ((phase_q == PH_IDLE) || (phase_q == PH_UNLOCK_START)) ? 8'd0 : poll_q;
		poll_inc   = poll_cur + 8'd1;
		ok_code    = poll_lock ? MSG_LOCK_OK : MSG_UNLOCK_OK;
		ok_bit     = poll_lock ? OUT_LOCK_OK : OUT_UNLOCK_OK;
		poll_ph    = poll_lock ? PH_LOCK_POLL : PH_UNLOCK_POLL;
		fail_ph    = poll_lock ? PH_LOCK_FAIL : PH_UNLOCK_FAIL;
		next_ph    = poll_lock ? PH_UNLOCK_START : PH_SUMMARY;

		phase_d   = phase_q;
		wait_d    = wait_q;
		poll_d    = poll_q;
		outcome_d = outcome_q;
		drive_d   = drive_q;
		msg_v     = 1'b0;
		msg_c     = MSG_NONE;

		if (wait_q != 16'd0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			case (phase_q)
				PH_IDLE, PH_LOCK_POLL, PH_UNLOCK_START, PH_UNLOCK_POLL: begin
					if (phase_q == PH_IDLE && reed_level) begin
						drive_d = DRV_STOP;
						msg_v   = 1'b1;
						msg_c   = MSG_NO_HELMET;
						wait_d  = wait_load(cfg.absent_hold_ms);
						phase_d = PH_IDLE;
					end else begin
						if (phase_q == PH_IDLE) begin
							drive_d = DRV_FWD;
						end else if (phase_q == PH_UNLOCK_START) begin
							drive_d = DRV_REV;
						end
						poll_d = poll_cur;
						if (poll_cur >= cfg.timeout_polls) begin
							drive_d = DRV_STOP;
							msg_v   = 1'b1;
							msg_c   = ok_code + 4'd1;
							wait_d  = wait_load(cfg.result_hold_ms);
							phase_d = next_ph;
						end else if (!poll_level) begin
							outcome_d = outcome_q | ok_bit;
							drive_d   = DRV_STOP;
							msg_v     = 1'b1;
							msg_c     = ok_code;
							wait_d    = wait_load(cfg.result_hold_ms);
							phase_d   = next_ph;
						end else begin
							poll_d  = poll_inc;
							wait_d  = wait_load({8'd0, cfg.poll_ms});
							phase_d = (poll_inc >= cfg.timeout_polls) ? fail_ph : poll_ph;
						end
					end
				end
				PH_LOCK_FAIL, PH_UNLOCK_FAIL: begin
					drive_d = DRV_STOP;
					msg_v   = 1'b1;
					msg_c   = (phase_q == PH_LOCK_FAIL) ? MSG_LOCK_OK + 4'd1
					                                    : MSG_UNLOCK_OK + 4'd1;
					wait_d  = wait_load(cfg.result_hold_ms);
					phase_d = (phase_q == PH_LOCK_FAIL) ? PH_UNLOCK_START : PH_SUMMARY;
				end
				PH_SUMMARY: begin
					drive_d   = DRV_STOP;
					msg_v     = 1'b1;
					msg_c     = MSG_SUMMARY + {2'd0, outcome_q};
					outcome_d = 2'd0;
					wait_d    = wait_load(cfg.summary_hold_ms);
					phase_d   = PH_CENTER;
				end
				PH_CENTER: begin
					drive_d = DRV_FWD;
					wait_d  = wait_load(cfg.center_pulse_ms);
					phase_d = PH_SETTLE;
				end
				PH_SETTLE: begin
					drive_d = DRV_STOP;
					wait_d  = wait_load(cfg.settle_ms);
					phase_d = PH_IDLE;
				end
				default: begin
					drive_d = DRV_STOP;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			wait_q      <= 16'd0;
			poll_q      <= 8'd0;
			outcome_q   <= 2'd0;
			drive_q     <= DRV_STOP;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				wait_q      <= wait_d;
				poll_q      <= poll_d;
				outcome_q   <= outcome_d;
				drive_q     <= drive_d;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_drive_q <= drive_d;
			out_msg_v_q <= msg_v;
			out_msg_c_q <= msg_c;
		end
	end

	assign result_valid  = out_valid_q;
	assign motor_drive   = out_drive_q;
	assign message_valid = out_msg_v_q;
	assign message_code  = out_msg_c_q;

endmodule
